[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// consequent must hold in the cycle after antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, codes, types and step functions of the matrix-to-quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int E_W       = 18;                 // rotation element
  localparam int T_W       = 32;                 // translation element
  localparam int Q_W       = 18;                 // quaternion component
  localparam int SUM_W     = E_W + 2;            // diagonal sum
  localparam int D_W       = E_W + 1;            // off-diagonal sum/difference
  localparam int ARG_W     = SUM_W;              // smax + one
  localparam int RAD_W     = ((ARG_W + FRAC_BITS - 2 + 1) / 2) * 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DEN_W     = ROOT_W + 2;
  localparam int NUM_W     = D_W + FRAC_BITS;
  localparam int QUO_W     = NUM_W - DEN_W + 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // winning diagonal sum
  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  // per-request data carried along the back pipeline
  typedef struct packed {
    logic [1:0]                best;
    logic [2:0][D_W-1:0]       d;     // other components, ascending index
    logic [T_W-1:0]            tx;
    logic [T_W-1:0]            ty;
    logic [T_W-1:0]            tz;
  } rmq_side_t;

  // classified request held in the queue
  typedef struct packed {
    logic [ARG_W-1:0] arg;
    rmq_side_t        side;
  } rmq_item_t;

  // one square-root stage
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } rmq_sq_t;

  // one divider stage
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] num;
  } rmq_dv_t;

  // one result bit of the digit-by-digit square root
  function automatic rmq_sq_t sqrt_step(rmq_sq_t s);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    rmq_sq_t          n;
    t      = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, s.root, 2'b01};
    n.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = REM_W'(t - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = t[REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of restoring division
  function automatic rmq_dv_t div_step(rmq_dv_t s, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    rmq_dv_t        n;
    t     = {s.rem, s.num[QUO_W-1]};
    n.num = {s.num[QUO_W-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      n.rem = DEN_W'(t - {1'b0, den});
      n.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = t[DEN_W-1:0];
      n.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // apply sign and clamp to the component range
  function automatic logic [Q_W-1:0] sat_q(logic neg, logic [QUO_W-1:0] mag);
    logic [QUO_W:0] m;
    logic [QUO_W:0] neg_m;
    logic [Q_W-1:0] r;
    m     = {1'b0, mag};
    neg_m = (QUO_W+1)'(0) - m;
    if (!neg) begin
      r = (m > (QUO_W+1)'(Q_MAX)) ? Q_MAX : Q_W'(m);
    end else begin
      r = (m > (QUO_W+1)'({1'b0, Q_MIN})) ? Q_MIN : Q_W'(neg_m);
    end
    return r;
  endfunction

endpackage

[rtl/core/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Forms the diagonal sums, picks the winner and gathers the three numerators.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic signed [E_W-1:0] r00,
  input  logic signed [E_W-1:0] r01,
  input  logic signed [E_W-1:0] r02,
  input  logic signed [E_W-1:0] r10,
  input  logic signed [E_W-1:0] r11,
  input  logic signed [E_W-1:0] r12,
  input  logic signed [E_W-1:0] r20,
  input  logic signed [E_W-1:0] r21,
  input  logic signed [E_W-1:0] r22,
  input  logic [T_W-1:0]        tx,
  input  logic [T_W-1:0]        ty,
  input  logic [T_W-1:0]        tz,
  output rmq_item_t             item
);

  localparam logic [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] a, b, c;
  logic signed [SUM_W-1:0] s0, s1, s2, s3, smax;
  logic signed [D_W-1:0]   dm12, dm20, dm01, dp01, dp02, dp12;
  logic [1:0]              best;

  // diagonal sums
  assign a  = SUM_W'(r00);
  assign b  = SUM_W'(r11);
  assign c  = SUM_W'(r22);
  assign s0 = a + b + c;
  assign s1 = a - b - c;
  assign s2 = b - a - c;
  assign s3 = c - a - b;

  // largest sum, earliest on a tie
  always_comb begin
    best = SEL_W;
    smax = s0;
    if (s1 > smax) begin
      best = SEL_X;
      smax = s1;
    end
    if (s2 > smax) begin
      best = SEL_Y;
      smax = s2;
    end
    if (s3 > smax) begin
      best = SEL_Z;
      smax = s3;
    end
  end

  // off-diagonal terms
  assign dm12 = D_W'(r12) - D_W'(r21);
  assign dm20 = D_W'(r20) - D_W'(r02);
  assign dm01 = D_W'(r01) - D_W'(r10);
  assign dp01 = D_W'(r01) + D_W'(r10);
  assign dp02 = D_W'(r02) + D_W'(r20);
  assign dp12 = D_W'(r21) + D_W'(r12);

  always_comb begin
    item.arg       = ARG_W'(smax) + ONE;
    item.side.best = best;
    item.side.tx   = tx;
    item.side.ty   = ty;
    item.side.tz   = tz;
    case (best)
      SEL_W:   item.side.d = {dm01, dm20, dm12};
      SEL_X:   item.side.d = {dp02, dp01, dm12};
      SEL_Y:   item.side.d = {dp12, dp01, dm20};
      default: item.side.d = {dp12, dp02, dm01};
    endcase
  end

endmodule

[rtl/core/rmq_queue.sv]
// ----------------------------------------------------------------------------
// rmq_queue
// Short queue between the classify front and the arithmetic back end.
// ----------------------------------------------------------------------------
module rmq_queue import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmq_item_t         push_item,
  input  logic              pop,
  output rmq_item_t         head,
  output logic              full,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  rmq_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined square root, one result bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  rmq_side_t         in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output rmq_side_t         out_side
);

  rmq_sq_t   st_r   [ROOT_W];
  rmq_side_t side_r [ROOT_W];
  logic [ROOT_W-1:0] vld_r;
  rmq_sq_t   init;

  assign init = '{rem: '0, root: '0, rad: in_rad};

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-2:0], in_vld};
    end
  end

  // one stage per root bit
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k]   <= sqrt_step(init);
          side_r[k] <= in_side;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k]   <= sqrt_step(st_r[k-1]);
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = st_r[ROOT_W-1].root;
  assign out_side = side_r[ROOT_W-1];

endmodule

[rtl/core/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Three pipelined restoring dividers: rounded d * 2^F / (4c) magnitudes.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [ROOT_W-1:0]     in_c,
  input  rmq_side_t             in_side,
  output logic                  out_vld,
  output logic [ROOT_W-1:0]     out_c,
  output logic [2:0][QUO_W-1:0] out_quo,
  output logic [2:0]            out_neg,
  output rmq_side_t             out_side
);

  // prep stage: magnitudes and rounded numerators
  rmq_dv_t        prep_r [3];
  logic [2:0]     neg_r  [QUO_W+1];
  logic [ROOT_W-1:0] c_r [QUO_W+1];
  rmq_side_t      side_r [QUO_W+1];
  rmq_dv_t        st_r   [QUO_W][3];
  logic [QUO_W:0] vld_r;
  logic [2:0]     neg_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-1:0], in_vld};
    end
  end

  // sign of each numerator
  assign neg_in = {in_side.d[2][D_W-1], in_side.d[1][D_W-1], in_side.d[0][D_W-1]};

  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic signed [D_W-1:0] d;
    logic [D_W-1:0]        mag;
    logic [NUM_W-1:0]      num;
    assign d   = $signed(in_side.d[l]);
    assign mag = d[D_W-1] ? D_W'(-d) : D_W'(d);
    assign num = {mag, {FRAC_BITS{1'b0}}} + NUM_W'({in_c, 1'b0});
    always_ff @(posedge clk) begin
      if (en) begin
        prep_r[l] <= '{rem: DEN_W'(num[NUM_W-1:QUO_W]), quo: '0,
                       num: num[QUO_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= neg_in;
      c_r[0]    <= in_c;
      side_r[0] <= in_side;
    end
  end

  // one quotient bit per stage and lane
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] den;
    assign den = {c_r[k], 2'b00};
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k+1]  <= neg_r[k];
        c_r[k+1]    <= c_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en) begin
            st_r[k][l] <= div_step(prep_r[l], den);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en) begin
            st_r[k][l] <= div_step(st_r[k-1][l], den);
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[QUO_W];
  assign out_c    = c_r[QUO_W];
  assign out_neg  = neg_r[QUO_W];
  assign out_side = side_r[QUO_W];
  assign out_quo  = {st_r[QUO_W-1][2].quo, st_r[QUO_W-1][1].quo, st_r[QUO_W-1][0].quo};

endmodule

[rtl/core/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation (Q2.16) to a saturated Q2.16 quaternion by the
// largest-diagonal method; the Q16.16 translation rides along unchanged. One
// request is taken per clock while in_stall is low; a request's result
// passes through the queue, 17 square-root stages, one numerator stage and
// 18 divider stages before the output register, and the back end holds
// while a valid output is stalled. A four-entry queue separates the
// classify front from the arithmetic back end, so in_stall rises only once
// four requests are waiting behind a stalled output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [E_W-1:0] in_r00,
  input  logic signed [E_W-1:0] in_r01,
  input  logic signed [E_W-1:0] in_r02,
  input  logic signed [E_W-1:0] in_r10,
  input  logic signed [E_W-1:0] in_r11,
  input  logic signed [E_W-1:0] in_r12,
  input  logic signed [E_W-1:0] in_r20,
  input  logic signed [E_W-1:0] in_r21,
  input  logic signed [E_W-1:0] in_r22,
  input  logic signed [T_W-1:0] in_tx,
  input  logic signed [T_W-1:0] in_ty,
  input  logic signed [T_W-1:0] in_tz,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] out_quat_w,
  output logic signed [Q_W-1:0] out_quat_x,
  output logic signed [Q_W-1:0] out_quat_y,
  output logic signed [Q_W-1:0] out_quat_z,
  output logic signed [T_W-1:0] out_tx,
  output logic signed [T_W-1:0] out_ty,
  output logic signed [T_W-1:0] out_tz
);

  rmq_item_t         f_item, q_head;
  logic              q_full, q_empty, q_push, q_pop;
  logic [QCNT_W-1:0] q_count;
  logic              back_en;
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  rmq_side_t         sq_side;
  logic              dv_vld;
  logic [ROOT_W-1:0] dv_c;
  logic [2:0][QUO_W-1:0] dv_quo;
  logic [2:0]        dv_neg;
  rmq_side_t         dv_side;
  logic [Q_W-1:0]    cq, q0, q1, q2;
  logic [Q_W-1:0]    w_nxt, x_nxt, y_nxt, z_nxt;
  logic              out_valid_r;
  logic [Q_W-1:0]    w_r, x_r, y_r, z_r;
  logic [T_W-1:0]    tx_r, ty_r, tz_r;

  // front: classify and enqueue
  rmq_front u_front (
    .r00(in_r00), .r01(in_r01), .r02(in_r02),
    .r10(in_r10), .r11(in_r11), .r12(in_r12),
    .r20(in_r20), .r21(in_r21), .r22(in_r22),
    .tx(in_tx), .ty(in_ty), .tz(in_tz),
    .item(f_item)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign back_en  = !out_valid_r || !out_stall;
  assign q_pop    = back_en && !q_empty;

  rmq_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_item(f_item),
    .pop(q_pop), .head(q_head),
    .full(q_full), .empty(q_empty), .count(q_count)
  );

  // back: square root, then three dividers
  rmq_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(back_en),
    .in_vld(q_pop),
    .in_rad(RAD_W'({q_head.arg, {(FRAC_BITS-2){1'b0}}})),
    .in_side(q_head.side),
    .out_vld(sq_vld), .out_root(sq_root), .out_side(sq_side)
  );

  rmq_div u_div (
    .clk(clk), .rst_n(rst_n), .en(back_en),
    .in_vld(sq_vld), .in_c(sq_root), .in_side(sq_side),
    .out_vld(dv_vld), .out_c(dv_c), .out_quo(dv_quo),
    .out_neg(dv_neg), .out_side(dv_side)
  );

  // sign, clamp and place the components
  assign cq = Q_W'(dv_c);
  assign q0 = sat_q(dv_neg[0], dv_quo[0]);
  assign q1 = sat_q(dv_neg[1], dv_quo[1]);
  assign q2 = sat_q(dv_neg[2], dv_quo[2]);

  always_comb begin
    case (dv_side.best)
      SEL_W: begin
        w_nxt = cq; x_nxt = q0; y_nxt = q1; z_nxt = q2;
      end
      SEL_X: begin
        w_nxt = q0; x_nxt = cq; y_nxt = q1; z_nxt = q2;
      end
      SEL_Y: begin
        w_nxt = q0; x_nxt = q1; y_nxt = cq; z_nxt = q2;
      end
      default: begin
        w_nxt = q0; x_nxt = q1; y_nxt = q2; z_nxt = cq;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      w_r  <= w_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      tx_r <= dv_side.tx;
      ty_r <= dv_side.ty;
      tz_r <= dv_side.tz;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = w_r;
  assign out_quat_x = x_r;
  assign out_quat_y = y_r;
  assign out_quat_z = z_r;
  assign out_tx     = tx_r;
  assign out_ty     = ty_r;
  assign out_tz     = tz_r;

  // checks
  `ASSERT_ALWAYS(a_q_bound, clk, rst_n, q_count <= QCNT_W'(QDEPTH))
  `ASSERT_NEXT(a_q_grow, clk, rst_n, q_push && !q_pop, q_count == $past(q_count) + 1'b1)
  `ASSERT_NEXT(a_back_hold, clk, rst_n, !back_en, out_valid && $stable(out_quat_w))

endmodule
